// ----- hdl/bde_pkg.sv -----
// Shared types, register codes and pixel helper functions for the Bayer demosaic block.
// Used by bde_front, bde_back and the top level; depends on nothing.
package bde_pkg;

  localparam int CFG_DATA_W   = 13;
  localparam int RST_WIDTH    = 640;
  localparam int RST_HEIGHT   = 480;
  localparam int QUEUE_DEPTH  = 4;

  typedef enum logic [1:0] {
    REG_BAYER_ORDER  = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ORDER_GRBG = 2'd0,
    ORDER_GBRG = 2'd1,
    ORDER_BGGR = 2'd2,
    ORDER_RGGB = 2'd3
  } bayer_order_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    logic emit;
    logic top;
    logic bottom;
    logic first_col;
    logic last_col;
    logic row_odd;
    logic col_odd;
    logic width_two;
    logic last;
  } flags_t;

  // Rows two above to one below the pixel, columns two left to three right.
  typedef logic [3:0][5:0][7:0] up_win_t;
  // Row two below the pixel, columns two left to two right.
  typedef logic [4:0][7:0] low_win_t;

  function automatic logic [7:0] win_sample(up_win_t up, low_win_t low, int i, int j);
    logic [7:0] s;
    if (i == 4) begin
      s = low[j[2:0]];
    end else begin
      s = up[i[1:0]][j[2:0]];
    end
    return s;
  endfunction

  function automatic rgb_t diag_px(up_win_t up, low_win_t low, logic [1:0] ord,
                                   int dr, int dc, logic rp, logic cp);
    logic       lower;
    logic       left;
    int         i0;
    int         j0;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
    rgb_t       px;
    lower = rp ^ dr[0];
    left  = cp ^ dc[0];
    i0 = dr + 2 - int'(lower);
    j0 = dc + 2 - int'(left);
    a = win_sample(up, low, i0, j0);
    b = win_sample(up, low, i0, j0 + 1);
    c = win_sample(up, low, i0 + 1, j0);
    d = win_sample(up, low, i0 + 1, j0 + 1);
    unique case (bayer_order_t'(ord))
      ORDER_GRBG: begin
        px.red = b; px.blue = c; px.green = lower ? d : a;
      end
      ORDER_GBRG: begin
        px.red = c; px.blue = b; px.green = lower ? d : a;
      end
      ORDER_BGGR: begin
        px.red = d; px.blue = a; px.green = lower ? c : b;
      end
      ORDER_RGGB: begin
        px.red = a; px.blue = d; px.green = lower ? c : b;
      end
    endcase
    return px;
  endfunction

  function automatic rgb_t mix_px(rgb_t p, rgb_t q);
    rgb_t m;
    m.red   = {1'b0, p.red[7:1]} + {1'b0, q.red[7:1]};
    m.green = {1'b0, p.green[7:1]} + {1'b0, q.green[7:1]};
    m.blue  = {1'b0, p.blue[7:1]} + {1'b0, q.blue[7:1]};
    return m;
  endfunction

endpackage

// ----- hdl/bde_front.sv -----
// Front end of the Bayer demosaic block: input and output position counters and pixel class.
// Uses bde_pkg for the class flags.
module bde_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                restart,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                q_full,
  output logic                                push,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      use_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]     use_h,
  output logic [$clog2(MAX_WIDTH)-1:0]        col,
  output logic [$clog2(MAX_WIDTH)-1:0]        ncol,
  output bde_pkg::flags_t                     flags
);

  localparam int WB  = $clog2(MAX_WIDTH + 1);
  localparam int HB  = $clog2(MAX_HEIGHT + 1);
  localparam int CB  = $clog2(MAX_WIDTH);
  localparam int IRB = $clog2(MAX_HEIGHT + 3);
  localparam int ORB = $clog2(MAX_HEIGHT);

  logic [CB-1:0]  in_col, in_col_next;
  logic [IRB-1:0] in_row, in_row_next;
  logic [CB-1:0]  out_col, out_col_next;
  logic [ORB-1:0] out_row, out_row_next;
  logic           col_end;
  logic           emit;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign col      = in_col;

  always_comb begin
    col_end = (WB'(in_col) == use_w - WB'(1));
    emit    = (in_row > IRB'(2)) || ((in_row == IRB'(2)) && (in_col >= CB'(2)));
    ncol    = col_end ? '0 : in_col + CB'(1);

    flags.emit      = emit;
    flags.top       = (out_row == '0);
    flags.bottom    = (HB'(out_row) == use_h - HB'(1));
    flags.first_col = (out_col == '0);
    flags.last_col  = (WB'(out_col) == use_w - WB'(1));
    flags.row_odd   = out_row[0];
    flags.col_odd   = out_col[0];
    flags.width_two = (use_w == WB'(2));
    flags.last      = flags.bottom && flags.last_col;

    in_col_next  = col_end ? '0 : in_col + CB'(1);
    in_row_next  = col_end ? in_row + IRB'(1) : in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    if (emit) begin
      out_col_next = flags.last_col ? '0 : out_col + CB'(1);
      out_row_next = flags.last_col ? out_row + ORB'(1) : out_row;
    end
    if (emit && flags.last) begin
      in_col_next  = '0;
      in_row_next  = '0;
      out_col_next = '0;
      out_row_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (push) begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

endmodule

// ----- hdl/bde_fifo.sv -----
// Short item queue between the front end and the pixel pipeline of the Bayer demosaic block.
// Standalone; no package use.
module bde_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [NW-1:0]    count;

  assign full  = (count == NW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

// ----- hdl/bde_back.sv -----
// Pixel pipeline of the Bayer demosaic block: line memory, sample window, interpolation, output.
// Uses bde_pkg for window types and the quad and mixing functions.
module bde_back #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [1:0]                      bayer_order,
  input  logic                            q_empty,
  output logic                            q_pop,
  input  logic [7:0]                      q_sample,
  input  logic [$clog2(MAX_WIDTH)-1:0]    q_col,
  input  logic [$clog2(MAX_WIDTH)-1:0]    q_ncol,
  input  bde_pkg::flags_t                 q_flags,
  output logic                            m_valid,
  input  logic                            m_ready,
  output bde_pkg::rgb_t                   m_pixel,
  output logic                            m_last
);

  localparam int CB = $clog2(MAX_WIDTH);

  // Word k of a column holds the sample k+1 lines above the newest one.
  logic [3:0][7:0] lines [MAX_WIDTH];

  logic              en;
  logic              a_valid;
  logic [7:0]        a_sample;
  logic [CB-1:0]     a_col;
  bde_pkg::flags_t   a_flags;
  logic [3:0][7:0]   a_rd;
  logic              a_fwd;
  logic [3:0][7:0]   a_fwd_data;
  logic [3:0][7:0]   rd_eff;
  logic [3:0][7:0]   wr_word;

  bde_pkg::up_win_t  up;
  bde_pkg::low_win_t low;
  logic              b_valid;
  bde_pkg::flags_t   b_flags;

  logic              c_valid;
  bde_pkg::flags_t   c_flags;
  bde_pkg::rgb_t     c_p0, c_pw, c_pe, c_pn, c_ps, c_pe2;

  logic              o_valid;
  bde_pkg::rgb_t     o_pix;
  logic              o_last;
  bde_pkg::rgb_t     pix_sel;
  logic [6:0]        gw, ge, gn, gs;
  logic [6:0]        dh, dv;

  assign en      = !o_valid || m_ready;
  assign q_pop   = en && !q_empty;
  assign m_valid = o_valid;
  assign m_pixel = o_pix;
  assign m_last  = o_last;

  assign wr_word = {up[1][5], up[2][5], up[3][5], a_sample};
  assign rd_eff  = a_fwd ? a_fwd_data : a_rd;

  always_ff @(posedge clk) begin
    if (en && a_valid) begin
      lines[a_col] <= wr_word;
    end
    if (en) begin
      a_rd <= lines[q_ncol];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      o_valid <= 1'b0;
      a_fwd   <= 1'b0;
    end else if (en) begin
      a_valid <= q_pop;
      a_fwd   <= a_valid && (q_ncol == a_col);
      b_valid <= a_valid;
      c_valid <= b_valid && b_flags.emit;
      o_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sample   <= q_sample;
      a_col      <= q_col;
      a_flags    <= q_flags;
      a_fwd_data <= wr_word;
      b_flags    <= a_flags;
      c_flags    <= b_flags;
      c_p0  <= bde_pkg::diag_px(up, low, bayer_order, 0, 0, b_flags.row_odd, b_flags.col_odd);
      c_pw  <= bde_pkg::diag_px(up, low, bayer_order, 0, -1, b_flags.row_odd, b_flags.col_odd);
      c_pe  <= bde_pkg::diag_px(up, low, bayer_order, 0, 1, b_flags.row_odd, b_flags.col_odd);
      c_pn  <= bde_pkg::diag_px(up, low, bayer_order, -1, 0, b_flags.row_odd, b_flags.col_odd);
      c_ps  <= bde_pkg::diag_px(up, low, bayer_order, 1, 0, b_flags.row_odd, b_flags.col_odd);
      c_pe2 <= bde_pkg::diag_px(up, low, bayer_order, 0, 2, b_flags.row_odd, b_flags.col_odd);
      if (c_valid) begin
        o_pix  <= pix_sel;
        o_last <= c_flags.last;
      end
    end
    if (en && a_valid) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 5; j++) begin
          up[i][j] <= up[i][j+1];
        end
        up[i][5] <= rd_eff[3-i];
      end
      for (int j = 0; j < 4; j++) begin
        low[j] <= low[j+1];
      end
      low[4] <= a_sample;
    end
  end

  always_comb begin
    gw = c_pw.green[7:1];
    ge = c_pe.green[7:1];
    gn = c_pn.green[7:1];
    gs = c_ps.green[7:1];
    dh = (gw > ge) ? gw - ge : ge - gw;
    dv = (gn > gs) ? gn - gs : gs - gn;
    if (c_flags.top || c_flags.bottom) begin
      // The bottom right pixel repeats its left neighbor, sent just before it.
      if (c_flags.bottom && c_flags.last_col && !c_flags.top) begin
        pix_sel = o_pix;
      end else if (c_flags.bottom && c_flags.last_col) begin
        pix_sel = o_pix;
      end else if (c_flags.top && c_flags.first_col) begin
        pix_sel = c_flags.width_two ? c_p0 : bde_pkg::mix_px(c_p0, c_pe2);
      end else if (c_flags.row_odd == c_flags.col_odd) begin
        pix_sel = c_p0;
      end else if (c_flags.first_col) begin
        pix_sel = c_pe;
      end else if (c_flags.last_col) begin
        pix_sel = c_pw;
      end else begin
        pix_sel = bde_pkg::mix_px(c_pw, c_pe);
      end
    end else if (c_flags.row_odd == c_flags.col_odd) begin
      pix_sel = c_p0;
    end else if (c_flags.first_col || c_flags.last_col) begin
      pix_sel = bde_pkg::mix_px(c_pn, c_ps);
    end else if (dh < dv) begin
      pix_sel = bde_pkg::mix_px(c_pw, c_pe);
    end else begin
      pix_sel = bde_pkg::mix_px(c_pn, c_ps);
    end
  end

endmodule

// ----- hdl/bayer_demosaic_edge_directed.sv -----
// Edge-directed Bayer demosaic, top level: configuration registers, front end, queue, pipeline.
// A result moves through the queue and registers a, b, c and o after its releasing item is taken;
// one item per cycle unless the output stalls, set by one line memory read and write each cycle.
// The first result of a frame is released by item 2*width+2; each later item releases one.
// Reset is synchronous: counters, queue and pipeline valids clear and registers take defaults;
// the line memory is not cleared, since every sample used within a frame comes from that frame.
module bayer_demosaic_edge_directed #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [bde_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // raw_sample
  input  logic                            s_axis_tuser,  // drain
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,  // red, green, blue
  output logic                            m_axis_tlast   // frame_end
);

  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int HB    = $clog2(MAX_HEIGHT + 1);
  localparam int CB    = $clog2(MAX_WIDTH);
  localparam int LIM_W = (MAX_WIDTH / 2) * 2;
  localparam int LIM_H = (MAX_HEIGHT / 2) * 2;
  localparam int RST_W = (bde_pkg::RST_WIDTH > LIM_W) ? LIM_W : bde_pkg::RST_WIDTH;
  localparam int RST_H = (bde_pkg::RST_HEIGHT > LIM_H) ? LIM_H : bde_pkg::RST_HEIGHT;
  localparam int QW    = 8 + 2 * CB + $bits(bde_pkg::flags_t);

  logic [1:0]      bayer_order;
  logic [WB-1:0]   use_w, use_w_next;
  logic [HB-1:0]   use_h, use_h_next;
  logic            restart;

  logic            push;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  logic [CB-1:0]   f_col, f_ncol;
  bde_pkg::flags_t f_flags;
  logic [QW-1:0]   q_wdata, q_rdata;
  logic [7:0]      h_sample;
  logic [CB-1:0]   h_col, h_ncol;
  bde_pkg::flags_t h_flags;
  bde_pkg::rgb_t   pixel;

  always_comb begin
    int wv;
    int hv;
    wv = int'({cfg_data[11:1], 1'b0});
    hv = int'({cfg_data[12:1], 1'b0});
    if (wv < 2) wv = 2;
    if (wv > LIM_W) wv = LIM_W;
    if (hv < 2) hv = 2;
    if (hv > LIM_H) hv = LIM_H;
    use_w_next = WB'(wv);
    use_h_next = HB'(hv);
  end

  assign restart = cfg_we && ((cfg_index == bde_pkg::REG_BAYER_ORDER) ||
                              (cfg_index == bde_pkg::REG_FRAME_WIDTH) ||
                              (cfg_index == bde_pkg::REG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      bayer_order <= bde_pkg::ORDER_GRBG;
      use_w       <= WB'(RST_W);
      use_h       <= HB'(RST_H);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bde_pkg::REG_BAYER_ORDER:  bayer_order <= cfg_data[1:0];
        bde_pkg::REG_FRAME_WIDTH:  use_w <= use_w_next;
        bde_pkg::REG_FRAME_HEIGHT: use_h <= use_h_next;
        default: begin
        end
      endcase
    end
  end

  bde_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .q_full   (q_full),
    .push     (push),
    .use_w    (use_w),
    .use_h    (use_h),
    .col      (f_col),
    .ncol     (f_ncol),
    .flags    (f_flags)
  );

  assign q_wdata = {f_flags, f_ncol, f_col, s_axis_tdata};
  assign {h_flags, h_ncol, h_col, h_sample} = q_rdata;

  bde_fifo #(
    .WIDTH (QW),
    .DEPTH (bde_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  bde_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .bayer_order (bayer_order),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_sample    (h_sample),
    .q_col       (h_col),
    .q_ncol      (h_ncol),
    .q_flags     (h_flags),
    .m_valid     (m_axis_tvalid),
    .m_ready     (m_axis_tready),
    .m_pixel     (pixel),
    .m_last      (m_axis_tlast)
  );

  assign m_axis_tdata = pixel;

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for bayer_demosaic_edge_directed: random and directed raw frames,
// per-pixel prediction of RGB and frame end, random idling on both stream sides.
// Depends on hdl/bde_pkg.sv and hdl/bayer_demosaic_edge_directed.sv.
module tb;

  localparam int MAXW = 2048;
  localparam int MAXH = 4096;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [7:0] raw;
    logic       drain;
  } raw_item_t;

  typedef struct {
    bde_pkg::rgb_t px;
    logic last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [bde_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // raw_sample
  logic s_axis_tuser = 1'b0;       // drain
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // red, green, blue
  logic m_axis_tlast;              // frame_end

  bayer_demosaic_edge_directed uut (.*);

  always #5 clk = ~clk;

  raw_item_t pending_items[$];
  pixel_t    expected_pixels[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit item_taken = 1'b0;
  int mismatches = 0;
  int pixels_checked = 0;
  int frames_sent = 0;
  int quiet_cycles = 0;
  int unsigned items_queued = 0;

  // Predictor state.
  logic [7:0]  line_ring[8*MAXW];
  logic [1:0]  p_order = bde_pkg::ORDER_GRBG;
  logic [11:0] p_width = 12'(bde_pkg::RST_WIDTH);
  logic [12:0] p_height = 13'(bde_pkg::RST_HEIGHT);
  int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;

  function automatic int unsigned eff_width();
    int unsigned w;
    w = p_width & ~32'd1;
    if (w < 2) w = 2;
    if (w > MAXW) w = MAXW;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = p_height & ~32'd1;
    if (h < 2) h = 2;
    if (h > MAXH) h = MAXH;
    return h;
  endfunction

  function automatic logic [7:0] raw_at(int unsigned row, int unsigned col);
    return line_ring[(row & 7) * MAXW + (col % MAXW)];
  endfunction

  function automatic bde_pkg::rgb_t quad_pixel(int unsigned row, int unsigned col);
    int unsigned qr, qc;
    logic [7:0] a, b, c, d;
    logic lower;
    bde_pkg::rgb_t px;
    qr = row & ~32'd1;
    qc = col & ~32'd1;
    a = raw_at(qr, qc);
    b = raw_at(qr, qc + 1);
    c = raw_at(qr + 1, qc);
    d = raw_at(qr + 1, qc + 1);
    lower = row[0];
    case (bde_pkg::bayer_order_t'(p_order))
      bde_pkg::ORDER_GRBG: begin px.red = b; px.blue = c; px.green = lower ? d : a; end
      bde_pkg::ORDER_GBRG: begin px.red = c; px.blue = b; px.green = lower ? d : a; end
      bde_pkg::ORDER_BGGR: begin px.red = d; px.blue = a; px.green = lower ? c : b; end
      default:             begin px.red = a; px.blue = d; px.green = lower ? c : b; end
    endcase
    return px;
  endfunction

  function automatic bde_pkg::rgb_t halve_sum(bde_pkg::rgb_t p, bde_pkg::rgb_t q);
    bde_pkg::rgb_t m;
    m.red   = (p.red >> 1) + (q.red >> 1);
    m.green = (p.green >> 1) + (q.green >> 1);
    m.blue  = (p.blue >> 1) + (q.blue >> 1);
    return m;
  endfunction

  function automatic bde_pkg::rgb_t border_pixel(int unsigned row, int unsigned col,
                                                 int unsigned w);
    if (((row ^ col) & 1) == 0) return quad_pixel(row, col);
    if (col == 0) return quad_pixel(row, 1);
    if (col == w - 1) return quad_pixel(row, w - 2);
    return halve_sum(quad_pixel(row, col - 1), quad_pixel(row, col + 1));
  endfunction

  function automatic bde_pkg::rgb_t demosaic_pixel(int unsigned row, int unsigned col,
                                                   int unsigned w, int unsigned h);
    int unsigned c, dh, dv;
    bde_pkg::rgb_t wp, ep, np, sp;
    if (row == 0 || row == h - 1) begin
      c = col;
      if (row == 0 && col == 0) c = 1;
      else if (row == h - 1 && col == w - 1) c = w - 2;
      return border_pixel(row, c, w);
    end
    if (((row ^ col) & 1) == 0) return quad_pixel(row, col);
    np = quad_pixel(row - 1, col);
    sp = quad_pixel(row + 1, col);
    if (col == 0 || col == w - 1) return halve_sum(np, sp);
    wp = quad_pixel(row, col - 1);
    ep = quad_pixel(row, col + 1);
    dh = (wp.green >> 1) > (ep.green >> 1) ? (wp.green >> 1) - (ep.green >> 1)
                                            : (ep.green >> 1) - (wp.green >> 1);
    dv = (np.green >> 1) > (sp.green >> 1) ? (np.green >> 1) - (sp.green >> 1)
                                            : (sp.green >> 1) - (np.green >> 1);
    return (dh < dv) ? halve_sum(wp, ep) : halve_sum(np, sp);
  endfunction

  function automatic void restart_frame();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endfunction

  function automatic void take_raw(logic [7:0] raw);
    int unsigned w, h;
    pixel_t e;
    w = eff_width();
    h = eff_height();
    if (in_col >= w) in_col = 0;
    if (in_row < h) line_ring[(in_row & 7) * MAXW + (in_col % MAXW)] = raw;
    if (in_row * w + in_col >= 2 * w + 2) begin
      e.px = demosaic_pixel(out_row, out_col, w, h);
      e.last = (out_row == h - 1 && out_col == w - 1);
      expected_pixels.push_back(e);
      if (e.last) begin
        restart_frame();
        return;
      end
      out_col++;
      if (out_col >= w) begin out_col = 0; out_row++; end
    end
    in_col++;
    if (in_col >= w) begin in_col = 0; in_row++; end
  endfunction

  // Monitor, predictor update and watchdog.
  always @(posedge clk) begin : mon
    pixel_t e;
    bde_pkg::rgb_t got;
    item_taken = 1'b0;
    if (!rst) begin
      if (cfg_we) begin
        quiet_cycles = 0;
        if (cfg_index == bde_pkg::REG_BAYER_ORDER) begin
          p_order = cfg_data[1:0]; restart_frame();
        end else if (cfg_index == bde_pkg::REG_FRAME_WIDTH) begin
          p_width = cfg_data[11:0]; restart_frame();
        end else if (cfg_index == bde_pkg::REG_FRAME_HEIGHT) begin
          p_height = cfg_data; restart_frame();
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        item_taken = 1'b1;
        quiet_cycles = 0;
        take_raw(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        quiet_cycles = 0;
        got = m_axis_tdata;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected pixel %h last %b", m_axis_tdata, m_axis_tlast);
        end else begin
          e = expected_pixels.pop_front();
          pixels_checked++;
          if (got.red !== e.px.red || got.green !== e.px.green || got.blue !== e.px.blue ||
              m_axis_tlast !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel mismatch: expected r%0d g%0d b%0d last %b, got r%0d g%0d b%0d last %b",
                       e.px.red, e.px.green, e.px.blue, e.last,
                       got.red, got.green, got.blue, m_axis_tlast);
          end
        end
      end
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("FAIL bayer_demosaic_edge_directed");
        $finish;
      end
    end
  end

  // Driver.
  always @(negedge clk) begin : drv
    raw_item_t it;
    logic v;
    if (!rst) begin
      v = s_axis_tvalid && !item_taken;
      if (!v && pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_items.pop_front();
        s_axis_tdata <= it.raw;
        s_axis_tuser <= it.drain;
        v = 1'b1;
      end
      s_axis_tvalid <= v;
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // The check runs just after the falling edge, once the driver has updated its outputs.
  task automatic wait_idle();
    @(negedge clk);
    #1;
    while (pending_items.size() > 0 || s_axis_tvalid || expected_pixels.size() > 0) begin
      @(negedge clk);
      #1;
    end
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = bde_pkg::CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Queues one frame; fixed_val < 0 gives random samples, else alternates it with its inverse.
  task automatic queue_frame(int fixed_val);
    raw_item_t it;
    int unsigned w, h;
    w = eff_width();
    h = eff_height();
    for (int unsigned i = 0; i < w * h; i++) begin
      it.raw = (fixed_val < 0) ? 8'($urandom) : ((i & 1) ? ~8'(fixed_val) : 8'(fixed_val));
      it.drain = ($urandom_range(7) == 0);
      pending_items.push_back(it);
    end
    for (int unsigned i = 0; i < 2 * w + 2; i++) begin
      it.raw = 8'($urandom);
      it.drain = ($urandom_range(5) != 0);
      pending_items.push_back(it);
    end
    items_queued += w * h + 2 * w + 2;
    frames_sent++;
  endtask

  task automatic setup(int ord, int w, int h);
    write_reg(bde_pkg::REG_BAYER_ORDER, ord);
    write_reg(bde_pkg::REG_FRAME_WIDTH, w);
    write_reg(bde_pkg::REG_FRAME_HEIGHT, h);
  endtask

  initial begin
    int unsigned start_count;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Default size is far too big to run; directed small frames cover each pattern order.
    for (int o = 0; o < 4; o++) begin
      setup(o, 2, 2);
      queue_frame(o[0] ? 255 : 0);
      wait_idle();
    end
    write_reg(REG_UNUSED, 5);
    setup(bde_pkg::ORDER_RGGB, 1, 0);  // odd sizes round down to even and too small sizes are raised to two
    queue_frame(-1);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      start_count = items_queued;
      while (items_queued - start_count < 120) begin
        setup($urandom_range(3), $urandom_range(17), $urandom_range(11));
        queue_frame(-1);
        if ($urandom_range(2) == 0) queue_frame(-1);
        wait_idle();
      end
    end

    wait_idle();
    $display("Ran %0d small and odd sized frames over all pattern orders and idle phases.",
             frames_sent);
    $display("%0d items sent and %0d pixels checked.", items_queued, pixels_checked);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("PASS bayer_demosaic_edge_directed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL bayer_demosaic_edge_directed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hdl/bde_pkg.sv
hdl/bde_front.sv
hdl/bde_fifo.sv
hdl/bde_back.sv
hdl/bayer_demosaic_edge_directed.sv
sim/tb.sv
